FILE: rtl/pwm_pkg.sv
// Shared constants, types and control structs for the pooling block.
package pwm_pkg;

	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_VALUE_BITS = 16;

	localparam int DIM_W   = 7;
	localparam int PAD_W   = 6;
	localparam int ROW_W   = 6;
	localparam int OUTC_W  = 8;
	localparam int COORD_W = 18;
	localparam int AREA_W  = 2 * DIM_W;
	localparam int POS_W   = 2 * DIM_W;
	localparam int MPOS_W  = 13;
	localparam int CFG_A_W = 3;

	localparam logic [CFG_A_W-1:0] CFG_POOL_MODE    = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_WINDOW_SIZE  = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_STEP_SIZE    = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_BORDER_PAD   = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_WHOLE_PLANE  = 3'd4;
	localparam logic [CFG_A_W-1:0] CFG_PLANE_HEIGHT = 3'd5;
	localparam logic [CFG_A_W-1:0] CFG_PLANE_WIDTH  = 3'd6;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;
	localparam logic MODE_MAX    = 1'b0;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic accept;
		logic bound;
		logic clip;
		logic area_init;
		logic scan;
		logic div_start;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic is_compute;
		logic avg;
		logic empty;
		logic last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/pooling_window_max_avg.sv
// Top level of the two-dimensional max and average pooling block.
// A load transaction writes one pixel into the plane store, if its row and column lie
// inside MAX_HEIGHT and MAX_WIDTH, and produces no result. A compute transaction pools
// one window and produces one result: it passes the bound, clip and area setup steps,
// then reads each stored pixel in the clipped window (k*k at most, or the whole plane
// in whole-plane mode; one read of the store port per cycle) and a drain step, then in
// average mode runs the bit-serial divider, then loads the output register once it is
// free. Inputs are accepted again as soon as the result is in the output register,
// even while it waits to be taken. The plane store has no reset.
module pooling_window_max_avg import pwm_pkg::*; #(
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_A_W-1:0]           cfg_addr,
	input  logic [DIM_W-1:0]             cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [ROW_W-1:0]             pix_row,
	input  logic [ROW_W-1:0]             pix_col,
	input  logic signed [VALUE_BITS-1:0] pix_value,
	input  logic [OUTC_W-1:0]            out_row,
	input  logic [OUTC_W-1:0]            out_col,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [VALUE_BITS-1:0] pooled_value,
	output logic signed [MPOS_W-1:0]     max_position
);

	cmd_t cmd;
	sts_t sts;

	pwm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	pwm_dp #(
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WIDTH (MAX_WIDTH),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.pix_row     (pix_row),
		.pix_col     (pix_col),
		.pix_value   (pix_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.pooled_value(pooled_value),
		.max_position(max_position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

FILE: rtl/pwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/pwm_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
module pwm_div #(
	parameter int DVD_W = 29,
	parameter int DVS_W = 14
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic        [DVS_W-1:0] divisor,
	output logic                    done,
	output logic signed [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic             neg_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			quo_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

FILE: rtl/pwm_ctrl.sv
// Sequencer for load and compute transactions of the pooling block.
module pwm_ctrl import pwm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BOUND = 4'd1;
	localparam logic [3:0] S_CLIP  = 4'd2;
	localparam logic [3:0] S_AREA  = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_DRAIN = 4'd5;
	localparam logic [3:0] S_DIVS  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.is_compute) begin
					state_d = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = S_CLIP;
			end
			S_CLIP: begin
				cmd.clip = 1'b1;
				state_d  = S_AREA;
			end
			S_AREA: begin
				cmd.area_init = 1'b1;
				if (!sts.empty) begin
					state_d = S_SCAN;
				end else begin
					state_d = sts.avg ? S_DIVS : S_FIN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = sts.avg ? S_DIVS : S_FIN;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded while output register is held");
	a_div_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == S_DIV) && !cmd.accept)
		else $error("divider start not followed by wait");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && sts.div_done |=> (state_q == S_FIN))
		else $error("divide completion not taken");
	a_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> in_stall)
		else $error("input accepted during window scan");
`endif

endmodule

FILE: rtl/pwm_dp.sv
// Datapath: configuration, plane store, window bounds, scan, accumulate, divide, result.
module pwm_dp import pwm_pkg::*; #(
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CFG_A_W-1:0]           cfg_addr,
	input  logic [DIM_W-1:0]             cfg_wr_data,
	input  logic                         req_type,
	input  logic [ROW_W-1:0]             pix_row,
	input  logic [ROW_W-1:0]             pix_col,
	input  logic signed [VALUE_BITS-1:0] pix_value,
	input  logic [OUTC_W-1:0]            out_row,
	input  logic [OUTC_W-1:0]            out_col,
	output logic signed [VALUE_BITS-1:0] pooled_value,
	output logic signed [MPOS_W-1:0]     max_position,
	output logic                         out_valid,
	input  logic                         out_stall,
	input  cmd_t                         cmd,
	output sts_t                         sts
);

	localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = VALUE_BITS + ADDR_W + 1;
	localparam int PROD_W = OUTC_W + DIM_W;

	logic             pool_mode_q;
	logic [DIM_W-1:0] window_size_q;
	logic [DIM_W-1:0] step_size_q;
	logic [PAD_W-1:0] border_pad_q;
	logic             whole_plane_q;
	logic [DIM_W-1:0] plane_height_q;
	logic [DIM_W-1:0] plane_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_mode_q    <= 1'b0;
			window_size_q  <= DIM_W'(2);
			step_size_q    <= DIM_W'(1);
			border_pad_q   <= '0;
			whole_plane_q  <= 1'b0;
			plane_height_q <= DIM_W'(64);
			plane_width_q  <= DIM_W'(64);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_POOL_MODE:    pool_mode_q    <= cfg_wr_data[0];
				CFG_WINDOW_SIZE:  window_size_q  <= cfg_wr_data;
				CFG_STEP_SIZE:    step_size_q    <= cfg_wr_data;
				CFG_BORDER_PAD:   border_pad_q   <= cfg_wr_data[PAD_W-1:0];
				CFG_WHOLE_PLANE:  whole_plane_q  <= cfg_wr_data[0];
				CFG_PLANE_HEIGHT: plane_height_q <= cfg_wr_data;
				CFG_PLANE_WIDTH:  plane_width_q  <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0] h_eff, w_eff, k_eff, s_eff;

	always_comb begin
		if (plane_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (int'(plane_height_q) > MAX_HEIGHT) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = plane_height_q;
		end
		if (plane_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (int'(plane_width_q) > MAX_WIDTH) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = plane_width_q;
		end
		k_eff = (window_size_q == '0) ? DIM_W'(1) : window_size_q;
		s_eff = (step_size_q == '0) ? DIM_W'(1) : step_size_q;
	end

	logic              ld_we;
	logic [ADDR_W-1:0] ld_addr;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] row_addr_q;
	logic [VALUE_BITS-1:0] rd_data;

	assign ld_we   = cmd.accept && (req_type == REQ_LOAD) && (int'(pix_row) < MAX_HEIGHT)
		&& (int'(pix_col) < MAX_WIDTH);
	assign ld_addr = ADDR_W'(int'(pix_row) * MAX_WIDTH + int'(pix_col));

	pwm_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ld_we),
		.waddr(ld_addr),
		.wdata(pix_value),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	logic [OUTC_W-1:0] orow_q, ocol_q;
	logic [PROD_W-1:0] prod_h, prod_w;
	coord_t h0_q, w0_q, hs_q, ws_q, he_q, we_q, hp_q, wp_q;
	coord_t h1, w1, hlim, wlim;
	coord_t hc_q, wc_q;
	logic [AREA_W-1:0] area_q;
	logic [POS_W-1:0]  pos_q, row_pos_q;

	assign prod_h = PROD_W'(orow_q) * PROD_W'(s_eff);
	assign prod_w = PROD_W'(ocol_q) * PROD_W'(s_eff);
	assign h1     = whole_plane_q ? coord_t'(h_eff) : h0_q + coord_t'(k_eff);
	assign w1     = whole_plane_q ? coord_t'(w_eff) : w0_q + coord_t'(k_eff);
	assign hlim   = coord_t'(h_eff) + coord_t'(border_pad_q);
	assign wlim   = coord_t'(w_eff) + coord_t'(border_pad_q);

	logic row_end;
	assign row_end = (wc_q + coord_t'(1)) == we_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			orow_q <= out_row;
			ocol_q <= out_col;
		end
		if (cmd.bound) begin
			h0_q <= whole_plane_q ? '0 : coord_t'(prod_h) - coord_t'(border_pad_q);
			w0_q <= whole_plane_q ? '0 : coord_t'(prod_w) - coord_t'(border_pad_q);
		end
		if (cmd.clip) begin
			hs_q <= (h0_q < 0) ? '0 : h0_q;
			ws_q <= (w0_q < 0) ? '0 : w0_q;
			he_q <= (h1 < coord_t'(h_eff)) ? h1 : coord_t'(h_eff);
			we_q <= (w1 < coord_t'(w_eff)) ? w1 : coord_t'(w_eff);
			hp_q <= ((h1 < hlim) ? h1 : hlim) - h0_q;
			wp_q <= ((w1 < wlim) ? w1 : wlim) - w0_q;
		end
		if (cmd.area_init) begin
			if (whole_plane_q) begin
				area_q <= AREA_W'(h_eff) * AREA_W'(w_eff);
			end else if (hp_q > 0 && wp_q > 0) begin
				area_q <= AREA_W'(hp_q[DIM_W-1:0]) * AREA_W'(wp_q[DIM_W-1:0]);
			end else begin
				area_q <= '0;
			end
			hc_q       <= hs_q;
			wc_q       <= ws_q;
			row_addr_q <= ADDR_W'(int'(hs_q[DIM_W-1:0]) * MAX_WIDTH + int'(ws_q[DIM_W-1:0]));
			addr_q     <= ADDR_W'(int'(hs_q[DIM_W-1:0]) * MAX_WIDTH + int'(ws_q[DIM_W-1:0]));
			row_pos_q  <= POS_W'(hs_q[DIM_W-1:0]) * POS_W'(w_eff)
				+ POS_W'(ws_q[DIM_W-1:0]);
			pos_q      <= POS_W'(hs_q[DIM_W-1:0]) * POS_W'(w_eff)
				+ POS_W'(ws_q[DIM_W-1:0]);
		end else if (cmd.scan) begin
			if (row_end) begin
				wc_q       <= ws_q;
				hc_q       <= hc_q + coord_t'(1);
				row_addr_q <= row_addr_q + ADDR_W'(MAX_WIDTH);
				addr_q     <= row_addr_q + ADDR_W'(MAX_WIDTH);
				row_pos_q  <= row_pos_q + POS_W'(w_eff);
				pos_q      <= row_pos_q + POS_W'(w_eff);
			end else begin
				wc_q   <= wc_q + coord_t'(1);
				addr_q <= addr_q + ADDR_W'(1);
				pos_q  <= pos_q + POS_W'(1);
			end
		end
	end

	logic rd_v_s1;
	logic [POS_W-1:0] rd_pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		rd_pos_s1 <= pos_q;
	end

	logic signed [SUM_W-1:0]      sum_q;
	logic signed [VALUE_BITS-1:0] max_q;
	logic                         found_q;
	logic [POS_W-1:0]             mpos_q;
	logic signed [VALUE_BITS-1:0] rd_val;

	assign rd_val = $signed(rd_data);

	always_ff @(posedge clk) begin
		if (cmd.area_init) begin
			sum_q   <= '0;
			max_q   <= {1'b1, {(VALUE_BITS-1){1'b0}}};
			found_q <= 1'b0;
			mpos_q  <= '0;
		end else if (rd_v_s1) begin
			sum_q <= sum_q + SUM_W'(rd_val);
			if (!found_q || rd_val > max_q) begin
				found_q <= 1'b1;
				max_q   <= rd_val;
				mpos_q  <= rd_pos_s1;
			end
		end
	end

	logic                    div_done;
	logic signed [SUM_W-1:0] quo;

	pwm_div #(
		.DVD_W(SUM_W),
		.DVS_W(AREA_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q),
		.divisor (area_q),
		.done    (div_done),
		.quotient(quo)
	);

	logic out_valid_q;
	logic signed [VALUE_BITS-1:0] pooled_q;
	logic signed [MPOS_W-1:0]     mpos_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (pool_mode_q == MODE_MAX) begin
				pooled_q   <= max_q;
				mpos_out_q <= found_q ? $signed(mpos_q[MPOS_W-1:0]) : '1;
			end else begin
				pooled_q   <= (area_q == '0) ? '0 : quo[VALUE_BITS-1:0];
				mpos_out_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pooled_value = pooled_q;
	assign max_position = mpos_out_q;

	assign sts.is_compute = (req_type == REQ_COMPUTE);
	assign sts.avg        = (pool_mode_q != MODE_MAX);
	assign sts.empty      = (hs_q >= he_q) || (ws_q >= we_q);
	assign sts.last       = row_end && ((hc_q + coord_t'(1)) == he_q);
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule
